/* rtl/ppv_pkg.sv */
package ppv_pkg;

    // vector and phase widths
    localparam int VEC_W   = 16;
    localparam int ANGLE_W = 16;
    localparam int FRAC_W  = VEC_W - 2;

    // cordic in q30, phase in 2^32 per turn
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] ONE_Q30     = 34'sd1073741824;

    // pipeline depths of the two sub-units
    localparam int PERP_LAT   = 2 * VEC_W + 3;
    localparam int SINCOS_LAT = CORDIC_STEPS + 4;

    typedef struct packed {
        logic signed [VEC_W-1:0] dir_x;
        logic signed [VEC_W-1:0] dir_y;
        logic signed [VEC_W-1:0] dir_z;
    } dir_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] dir_x;
        logic signed [VEC_W-1:0] dir_y;
        logic signed [VEC_W-1:0] dir_z;
        logic [ANGLE_W-1:0]      angle;
    } ppv_in_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] pol_x;
        logic signed [VEC_W-1:0] pol_y;
        logic signed [VEC_W-1:0] pol_z;
    } ppv_out_t;

    // arctangent of 2^-i in 2^32 per turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            24:      v = 32'h00000029;
            25:      v = 32'h00000014;
            26:      v = 32'h0000000A;
            27:      v = 32'h00000005;
            28:      v = 32'h00000003;
            29:      v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* rtl/ppv_perp.sv */
module ppv_perp (
    input  logic                              aclk,
    input  logic                              en,
    input  ppv_pkg::dir_t                     dir_in,
    output ppv_pkg::dir_t                     dir_out,
    output logic signed [ppv_pkg::FRAC_W+1:0] py_out,
    output logic signed [ppv_pkg::FRAC_W+1:0] pz_out
);

    localparam int W  = ppv_pkg::VEC_W;
    localparam int F  = ppv_pkg::FRAC_W;
    localparam int NW = 2 * W - 2;
    localparam int PW = F + 2;
    localparam logic signed [PW-1:0] P_ONE = PW'(1) << F;

    // squares of |dy| and |dz|
    logic [W-1:0]   ay, az;
    logic [2*W-1:0] ay2_reg, az2_reg, m2_reg;
    ppv_pkg::dir_t  d1_reg, d2_reg;
    logic           zero2_reg;

    assign ay = dir_in.dir_y[W-1] ? W'(~dir_in.dir_y + 1'b1) : W'(dir_in.dir_y);
    assign az = dir_in.dir_z[W-1] ? W'(~dir_in.dir_z + 1'b1) : W'(dir_in.dir_z);

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg    <= dir_in;
            ay2_reg   <= (2*W)'(ay) * (2*W)'(ay);
            az2_reg   <= (2*W)'(az) * (2*W)'(az);
            d2_reg    <= d1_reg;
            m2_reg    <= ay2_reg + az2_reg;
            zero2_reg <= (d1_reg.dir_y == '0) && (d1_reg.dir_z == '0);
        end
    end

    // restoring square root, one result bit per stage
    logic [2*W-1:0] sq_rem_reg  [W];
    logic [W-1:0]   sq_root_reg [W];
    ppv_pkg::dir_t  sq_d_reg    [W];
    logic           sq_zero_reg [W];

    for (genvar k = 0; k < W; k++) begin : g_sq
        localparam int B = W - 1 - k;
        logic [2*W-1:0] rem_in;
        logic [W-1:0]   root_in;
        ppv_pkg::dir_t  d_in;
        logic           zero_in;
        logic [2*W:0]   trial;
        logic           take;

        if (k == 0) begin : g_first
            assign rem_in  = m2_reg;
            assign root_in = '0;
            assign d_in    = d2_reg;
            assign zero_in = zero2_reg;
        end else begin : g_next
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign d_in    = sq_d_reg[k-1];
            assign zero_in = sq_zero_reg[k-1];
        end

        assign trial = ((2*W+1)'(root_in) << (B + 1)) + ((2*W+1)'(1) << (2 * B));
        assign take  = ({1'b0, rem_in} >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[k]  <= take ? (rem_in - trial[2*W-1:0]) : rem_in;
                sq_root_reg[k] <= take ? (root_in | (W'(1) << B)) : root_in;
                sq_d_reg[k]    <= d_in;
                sq_zero_reg[k] <= zero_in;
            end
        end
    end

    // rounded numerators for the two divisions
    ppv_pkg::dir_t  sd;
    logic [W-1:0]   r, sdy, sdz;
    logic [NW-1:0]  pre_ny_reg, pre_nz_reg;
    logic [W-1:0]   pre_den_reg;
    logic           pre_negy_reg, pre_negz_reg, pre_zero_reg;
    ppv_pkg::dir_t  pre_d_reg;

    assign sd  = sq_d_reg[W-1];
    assign r   = sq_root_reg[W-1];
    assign sdy = sd.dir_y[W-1] ? W'(~sd.dir_y + 1'b1) : W'(sd.dir_y);
    assign sdz = sd.dir_z[W-1] ? W'(~sd.dir_z + 1'b1) : W'(sd.dir_z);

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_ny_reg   <= {sdz, {F{1'b0}}} + NW'(r >> 1);
            pre_nz_reg   <= {sdy, {F{1'b0}}} + NW'(r >> 1);
            pre_den_reg  <= r;
            pre_negy_reg <= !sd.dir_z[W-1];
            pre_negz_reg <= sd.dir_y[W-1];
            pre_zero_reg <= sq_zero_reg[W-1];
            pre_d_reg    <= sd;
        end
    end

    // restoring division, quotient never exceeds one
    logic [NW-1:0] dv_ry_reg   [F+1];
    logic [NW-1:0] dv_rz_reg   [F+1];
    logic [F:0]    dv_qy_reg   [F+1];
    logic [F:0]    dv_qz_reg   [F+1];
    logic [W-1:0]  dv_den_reg  [F+1];
    logic          dv_negy_reg [F+1];
    logic          dv_negz_reg [F+1];
    logic          dv_zero_reg [F+1];
    ppv_pkg::dir_t dv_d_reg    [F+1];

    for (genvar j = 0; j <= F; j++) begin : g_dv
        localparam int K = F - j;
        logic [NW-1:0] ry_in, rz_in, sub;
        logic [F:0]    qy_in, qz_in;
        logic [W-1:0]  den_in;
        logic          negy_in, negz_in, zero_in, take_y, take_z;
        ppv_pkg::dir_t d_in;

        if (j == 0) begin : g_first
            assign ry_in   = pre_ny_reg;
            assign rz_in   = pre_nz_reg;
            assign qy_in   = '0;
            assign qz_in   = '0;
            assign den_in  = pre_den_reg;
            assign negy_in = pre_negy_reg;
            assign negz_in = pre_negz_reg;
            assign zero_in = pre_zero_reg;
            assign d_in    = pre_d_reg;
        end else begin : g_next
            assign ry_in   = dv_ry_reg[j-1];
            assign rz_in   = dv_rz_reg[j-1];
            assign qy_in   = dv_qy_reg[j-1];
            assign qz_in   = dv_qz_reg[j-1];
            assign den_in  = dv_den_reg[j-1];
            assign negy_in = dv_negy_reg[j-1];
            assign negz_in = dv_negz_reg[j-1];
            assign zero_in = dv_zero_reg[j-1];
            assign d_in    = dv_d_reg[j-1];
        end

        assign sub    = NW'(den_in) << K;
        assign take_y = (ry_in >= sub);
        assign take_z = (rz_in >= sub);

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_ry_reg[j]   <= take_y ? (ry_in - sub) : ry_in;
                dv_rz_reg[j]   <= take_z ? (rz_in - sub) : rz_in;
                dv_qy_reg[j]   <= take_y ? (qy_in | ((F+1)'(1) << K)) : qy_in;
                dv_qz_reg[j]   <= take_z ? (qz_in | ((F+1)'(1) << K)) : qz_in;
                dv_den_reg[j]  <= den_in;
                dv_negy_reg[j] <= negy_in;
                dv_negz_reg[j] <= negz_in;
                dv_zero_reg[j] <= zero_in;
                dv_d_reg[j]    <= d_in;
            end
        end
    end

    // signs, and the z axis when the direction lies along x
    logic signed [PW-1:0] qy_s, qz_s, py_reg, pz_reg;
    ppv_pkg::dir_t        d_out_reg;

    assign qy_s = $signed({1'b0, dv_qy_reg[F]});
    assign qz_s = $signed({1'b0, dv_qz_reg[F]});

    always_ff @(posedge aclk) begin
        if (en) begin
            d_out_reg <= dv_d_reg[F];
            if (dv_zero_reg[F]) begin
                py_reg <= '0;
                pz_reg <= P_ONE;
            end else begin
                py_reg <= dv_negy_reg[F] ? -qy_s : qy_s;
                pz_reg <= dv_negz_reg[F] ? -qz_s : qz_s;
            end
        end
    end

    assign dir_out = d_out_reg;
    assign py_out  = py_reg;
    assign pz_out  = pz_reg;

endmodule

/* rtl/ppv_sincos.sv */
module ppv_sincos (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [ppv_pkg::ANGLE_W-1:0]       angle_in,
    output logic signed [ppv_pkg::FRAC_W+1:0] cos_out,
    output logic signed [ppv_pkg::FRAC_W+1:0] sin_out
);

    localparam int AW = ppv_pkg::ANGLE_W;
    localparam int F  = ppv_pkg::FRAC_W;
    localparam int N  = ppv_pkg::CORDIC_STEPS;
    localparam int XW = ppv_pkg::CORDIC_W;
    localparam int PW = F + 2;
    localparam int SH = 30 - F;
    localparam logic signed [XW-1:0] RND_HALF = (XW'(1) << SH) >> 1;
    localparam logic                 RND_ADJ  = (SH > 0);

    // fold the second and third quarters onto the first and fourth
    logic [31:0]          t;
    logic                 fold;
    logic signed [XW-1:0] z0, pre_z_reg;
    logic                 pre_neg_reg;

    assign t    = {angle_in, {(32-AW){1'b0}}};
    assign fold = t[31] ^ t[30];
    assign z0   = $signed({{(XW-31){t[31] ^ fold}}, t[30:0]});

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_z_reg   <= z0;
            pre_neg_reg <= fold;
        end
    end

    logic signed [XW-1:0] cx_reg  [N];
    logic signed [XW-1:0] cy_reg  [N];
    logic signed [XW-1:0] cz_reg  [N];
    logic                 cneg_reg[N];

    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [XW-1:0] x_in, y_in, z_in, xs, ys, at;
        logic                 neg_in;

        if (i == 0) begin : g_first
            assign x_in   = ppv_pkg::CORDIC_GAIN;
            assign y_in   = '0;
            assign z_in   = pre_z_reg;
            assign neg_in = pre_neg_reg;
        end else begin : g_next
            assign x_in   = cx_reg[i-1];
            assign y_in   = cy_reg[i-1];
            assign z_in   = cz_reg[i-1];
            assign neg_in = cneg_reg[i-1];
        end

        assign xs = x_in >>> i;
        assign ys = y_in >>> i;
        assign at = $signed({{(XW-32){1'b0}}, ppv_pkg::atan_turn(i)});

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_in[XW-1]) begin
                    cx_reg[i] <= x_in - ys;
                    cy_reg[i] <= y_in + xs;
                    cz_reg[i] <= z_in - at;
                end else begin
                    cx_reg[i] <= x_in + ys;
                    cy_reg[i] <= y_in - xs;
                    cz_reg[i] <= z_in + at;
                end
                cneg_reg[i] <= neg_in;
            end
        end
    end

    // clamp, round to the output scale, then undo the fold
    logic signed [XW-1:0] xl, yl, cl_x_reg, cl_y_reg, x_sum, y_sum, x_sh, y_sh;
    logic                 cl_neg_reg, rd_neg_reg;
    logic signed [PW-1:0] rd_c_reg, rd_s_reg, cos_reg, sin_reg;

    assign xl = cx_reg[N-1];
    assign yl = cy_reg[N-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (xl > ppv_pkg::ONE_Q30) begin
                cl_x_reg <= ppv_pkg::ONE_Q30;
            end else if (xl < -ppv_pkg::ONE_Q30) begin
                cl_x_reg <= -ppv_pkg::ONE_Q30;
            end else begin
                cl_x_reg <= xl;
            end
            if (yl > ppv_pkg::ONE_Q30) begin
                cl_y_reg <= ppv_pkg::ONE_Q30;
            end else if (yl < -ppv_pkg::ONE_Q30) begin
                cl_y_reg <= -ppv_pkg::ONE_Q30;
            end else begin
                cl_y_reg <= yl;
            end
            cl_neg_reg <= cneg_reg[N-1];
        end
    end

    // half away from zero: negative values take one less before the floor shift
    assign x_sum = cl_x_reg + RND_HALF - $signed({{(XW-1){1'b0}}, cl_x_reg[XW-1] & RND_ADJ});
    assign y_sum = cl_y_reg + RND_HALF - $signed({{(XW-1){1'b0}}, cl_y_reg[XW-1] & RND_ADJ});
    assign x_sh  = x_sum >>> SH;
    assign y_sh  = y_sum >>> SH;

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_c_reg   <= x_sh[PW-1:0];
            rd_s_reg   <= y_sh[PW-1:0];
            rd_neg_reg <= cl_neg_reg;
            cos_reg    <= rd_neg_reg ? -rd_c_reg : rd_c_reg;
            sin_reg    <= rd_neg_reg ? -rd_s_reg : rd_s_reg;
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

/* rtl/photon_polarization_vector.sv */
// throughput: one item per cycle unless the result side stalls; the depth is set by
// the bit-per-stage square root and divider pipeline, the 30-step cordic runs beside
// it and is delayed to match
// a stall on the result side freezes every stage at once, nothing is dropped
// reset (aresetn low, synchronous) clears the stage valid bits only
module photon_polarization_vector (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ppv_pkg::ppv_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ppv_pkg::ppv_out_t m_data
);

    localparam int W   = ppv_pkg::VEC_W;
    localparam int F   = ppv_pkg::FRAC_W;
    localparam int PW  = F + 2;           // unit vector and cos/sin width
    localparam int EW  = W + 2;           // parallel vector width
    localparam int XPW = PW + W;          // cross product terms
    localparam int DW  = XPW + 1;         // cross product difference
    localparam int MW  = PW + EW;         // final products
    localparam int RW  = MW + 1;          // final sums
    localparam int QW  = RW - F;          // rounded sums before clamping
    localparam int L_V = ppv_pkg::PERP_LAT + 3;
    localparam int L_C = ppv_pkg::SINCOS_LAT;
    localparam int L_M = (L_V > L_C) ? L_V : L_C;
    localparam int DV  = L_M - L_V;
    localparam int DC  = L_M - L_C;
    localparam int TOT = L_M + 4;

    localparam logic signed [DW-1:0] X_HALF  = DW'(1) << (F - 1);
    localparam logic signed [RW-1:0] F_HALF  = RW'(1) << (F - 1);
    localparam logic signed [QW-1:0] POS_ONE = QW'(1) << F;
    localparam logic signed [QW-1:0] NEG_ONE = -POS_ONE;

    typedef struct packed {
        logic signed [EW-1:0] ex;
        logic signed [EW-1:0] ey;
        logic signed [EW-1:0] ez;
        logic signed [PW-1:0] py;
        logic signed [PW-1:0] pz;
    } vec_item_t;

    typedef struct packed {
        logic signed [PW-1:0] c;
        logic signed [PW-1:0] s;
    } cs_item_t;

    // whole pipeline moves when the output register is free or being taken
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // one valid bit per stage, travelling with the data
    logic [TOT-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[TOT-2:0], s_valid};
        end
    end

    assign m_valid = valid_reg[TOT-1];

    // perpendicular unit vector p = x cross d / |x cross d|
    ppv_pkg::dir_t        in_dir, p_dir;
    logic signed [PW-1:0] p_py, p_pz;

    assign in_dir.dir_x = s_data.dir_x;
    assign in_dir.dir_y = s_data.dir_y;
    assign in_dir.dir_z = s_data.dir_z;

    ppv_perp u_perp (
        .aclk    (aclk),
        .en      (en),
        .dir_in  (in_dir),
        .dir_out (p_dir),
        .py_out  (p_py),
        .pz_out  (p_pz)
    );

    // cos and sin of the polarisation angle
    logic signed [PW-1:0] sc_c, sc_s;

    ppv_sincos u_sincos (
        .aclk     (aclk),
        .en       (en),
        .angle_in (s_data.angle),
        .cos_out  (sc_c),
        .sin_out  (sc_s)
    );

    // parallel vector e = p cross d, three stages: products, difference, rounding
    logic signed [XPW-1:0] x1_a_reg, x1_b_reg, x1_ey_reg, x1_ez_reg;
    logic signed [PW-1:0]  x1_py_reg, x1_pz_reg, x2_py_reg, x2_pz_reg;
    logic signed [DW-1:0]  x2_ex_reg, x2_ey_reg, x2_ez_reg;
    logic signed [DW-1:0]  rx_ex, rx_ey, rx_ez;
    vec_item_t             x3_item_reg;

    // half away from zero as a single add ahead of the floor shift
    assign rx_ex = (x2_ex_reg + X_HALF - $signed({{(DW-1){1'b0}}, x2_ex_reg[DW-1]})) >>> F;
    assign rx_ey = (x2_ey_reg + X_HALF - $signed({{(DW-1){1'b0}}, x2_ey_reg[DW-1]})) >>> F;
    assign rx_ez = (x2_ez_reg + X_HALF - $signed({{(DW-1){1'b0}}, x2_ez_reg[DW-1]})) >>> F;

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_a_reg  <= XPW'(p_py) * XPW'(p_dir.dir_z);
            x1_b_reg  <= XPW'(p_pz) * XPW'(p_dir.dir_y);
            x1_ey_reg <= XPW'(p_pz) * XPW'(p_dir.dir_x);
            x1_ez_reg <= XPW'(p_py) * XPW'(p_dir.dir_x);
            x1_py_reg <= p_py;
            x1_pz_reg <= p_pz;

            x2_ex_reg <= DW'(x1_a_reg) - DW'(x1_b_reg);
            x2_ey_reg <= DW'(x1_ey_reg);
            x2_ez_reg <= -DW'(x1_ez_reg);
            x2_py_reg <= x1_py_reg;
            x2_pz_reg <= x1_pz_reg;

            x3_item_reg.ex <= rx_ex[EW-1:0];
            x3_item_reg.ey <= rx_ey[EW-1:0];
            x3_item_reg.ez <= rx_ez[EW-1:0];
            x3_item_reg.py <= x2_py_reg;
            x3_item_reg.pz <= x2_pz_reg;
        end
    end

    // line up the vector path and the cordic path
    vec_item_t vec_dly;
    cs_item_t  cs_in, cs_dly;

    assign cs_in.c = sc_c;
    assign cs_in.s = sc_s;

    if (DV == 0) begin : g_vec_direct
        assign vec_dly = x3_item_reg;
    end else begin : g_vec_delay
        vec_item_t line_reg [DV];
        always_ff @(posedge aclk) begin
            if (en) begin
                line_reg[0] <= x3_item_reg;
                for (int m = 1; m < DV; m++) begin
                    line_reg[m] <= line_reg[m-1];
                end
            end
        end
        assign vec_dly = line_reg[DV-1];
    end

    if (DC == 0) begin : g_cs_direct
        assign cs_dly = cs_in;
    end else begin : g_cs_delay
        cs_item_t line_reg [DC];
        always_ff @(posedge aclk) begin
            if (en) begin
                line_reg[0] <= cs_in;
                for (int m = 1; m < DC; m++) begin
                    line_reg[m] <= line_reg[m-1];
                end
            end
        end
        assign cs_dly = line_reg[DC-1];
    end

    // pol = cos*e + sin*p: products, sums, rounding, saturation into the output register
    logic signed [MW-1:0] f1_cex_reg, f1_cey_reg, f1_cez_reg, f1_spy_reg, f1_spz_reg;
    logic signed [RW-1:0] f2_x_reg, f2_y_reg, f2_z_reg;
    logic signed [RW-1:0] rf_x, rf_y, rf_z;
    logic signed [QW-1:0] f3_x_reg, f3_y_reg, f3_z_reg;
    ppv_pkg::ppv_out_t    out_reg;

    assign rf_x = (f2_x_reg + F_HALF - $signed({{(RW-1){1'b0}}, f2_x_reg[RW-1]})) >>> F;
    assign rf_y = (f2_y_reg + F_HALF - $signed({{(RW-1){1'b0}}, f2_y_reg[RW-1]})) >>> F;
    assign rf_z = (f2_z_reg + F_HALF - $signed({{(RW-1){1'b0}}, f2_z_reg[RW-1]})) >>> F;

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_cex_reg <= MW'(cs_dly.c) * MW'(vec_dly.ex);
            f1_cey_reg <= MW'(cs_dly.c) * MW'(vec_dly.ey);
            f1_cez_reg <= MW'(cs_dly.c) * MW'(vec_dly.ez);
            f1_spy_reg <= MW'(cs_dly.s) * MW'(vec_dly.py);
            f1_spz_reg <= MW'(cs_dly.s) * MW'(vec_dly.pz);

            f2_x_reg <= RW'(f1_cex_reg);
            f2_y_reg <= RW'(f1_cey_reg) + RW'(f1_spy_reg);
            f2_z_reg <= RW'(f1_cez_reg) + RW'(f1_spz_reg);

            f3_x_reg <= rf_x[QW-1:0];
            f3_y_reg <= rf_y[QW-1:0];
            f3_z_reg <= rf_z[QW-1:0];

            if (f3_x_reg > POS_ONE) begin
                out_reg.pol_x <= POS_ONE[W-1:0];
            end else if (f3_x_reg < NEG_ONE) begin
                out_reg.pol_x <= NEG_ONE[W-1:0];
            end else begin
                out_reg.pol_x <= f3_x_reg[W-1:0];
            end
            if (f3_y_reg > POS_ONE) begin
                out_reg.pol_y <= POS_ONE[W-1:0];
            end else if (f3_y_reg < NEG_ONE) begin
                out_reg.pol_y <= NEG_ONE[W-1:0];
            end else begin
                out_reg.pol_y <= f3_y_reg[W-1:0];
            end
            if (f3_z_reg > POS_ONE) begin
                out_reg.pol_z <= POS_ONE[W-1:0];
            end else if (f3_z_reg < NEG_ONE) begin
                out_reg.pol_z <= NEG_ONE[W-1:0];
            end else begin
                out_reg.pol_z <= f3_z_reg[W-1:0];
            end
        end
    end

    assign m_data = out_reg;

endmodule

/* bench/photon_polarization_vector_check.sv */
`timescale 1ns / 100ps

module photon_polarization_vector_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  ppv_pkg::ppv_in_t    s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  ppv_pkg::ppv_out_t   m_data,
    output int                  fail_count,
    output int                  pending
);

    localparam longint UNIT = longint'(1) << ppv_pkg::FRAC_W;

    ppv_pkg::ppv_out_t pol_queue[$];

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint rnd_shift(longint v, int sh);
        longint m;
        m = (mag(v) + (sh > 0 ? (longint'(1) << (sh - 1)) : 0)) >>> sh;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint flr_shift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint rnd_div(longint num, longint den);
        longint q;
        q = (mag(num) + (den >>> 1)) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint int_sqrt(longint x);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= x)
                r = r + (longint'(1) << b);
        end
        return r;
    endfunction

    function automatic longint lim(longint v, longint l);
        return v > l ? l : (v < -l ? -l : v);
    endfunction

    // quadrant folded cordic rotation giving cosine and sine at FRAC_W bits
    function automatic void rotate_phase(input logic [ppv_pkg::ANGLE_W-1:0] ang,
                                         output longint c, output longint s);
        logic [31:0] t;
        logic        flip;
        longint      x, y, z, xs, ys, at;
        t = 32'(ang) << (32 - ppv_pkg::ANGLE_W);
        flip = (t[31:30] == 2'd1) || (t[31:30] == 2'd2);
        if (flip)
            t = t + 32'h80000000;
        z = longint'($signed(t));
        x = longint'(ppv_pkg::CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < ppv_pkg::CORDIC_STEPS; i++) begin
            xs = flr_shift(x, i);
            ys = flr_shift(y, i);
            at = longint'(ppv_pkg::atan_turn(i));
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - at;
            end else begin
                x = x + ys; y = y - xs; z = z + at;
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = rnd_shift(lim(x, longint'(ppv_pkg::ONE_Q30)), 30 - ppv_pkg::FRAC_W);
        s = rnd_shift(lim(y, longint'(ppv_pkg::ONE_Q30)), 30 - ppv_pkg::FRAC_W);
    endfunction

    function automatic ppv_pkg::ppv_out_t polarisation(ppv_pkg::ppv_in_t d);
        longint dx, dy, dz, py, pz, ex, ey, ez, c, s, r, m2;
        longint px_r, py_r, pz_r;
        ppv_pkg::ppv_out_t o;
        dx = longint'(d.dir_x);
        dy = longint'(d.dir_y);
        dz = longint'(d.dir_z);
        py = 0;
        pz = UNIT;
        m2 = dy * dy + dz * dz;
        if (m2 > 0) begin
            r = int_sqrt(m2);
            py = rnd_div(-dz * UNIT, r);
            pz = rnd_div(dy * UNIT, r);
        end
        ex = rnd_shift(py * dz - pz * dy, ppv_pkg::FRAC_W);
        ey = rnd_shift(pz * dx, ppv_pkg::FRAC_W);
        ez = rnd_shift(-py * dx, ppv_pkg::FRAC_W);
        rotate_phase(d.angle, c, s);
        px_r = lim(rnd_shift(c * ex, ppv_pkg::FRAC_W), UNIT);
        py_r = lim(rnd_shift(c * ey + s * py, ppv_pkg::FRAC_W), UNIT);
        pz_r = lim(rnd_shift(c * ez + s * pz, ppv_pkg::FRAC_W), UNIT);
        o.pol_x = ppv_pkg::VEC_W'(px_r);
        o.pol_y = ppv_pkg::VEC_W'(py_r);
        o.pol_z = ppv_pkg::VEC_W'(pz_r);
        return o;
    endfunction

    always @(posedge aclk) begin
        ppv_pkg::ppv_out_t want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                pol_queue.push_back(polarisation(s_data));
            if (m_valid && m_ready) begin
                if (pol_queue.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result %h", m_data);
                end else begin
                    want = pol_queue.pop_front();
                    if (want !== m_data) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected x %0d y %0d z %0d, got x %0d y %0d z %0d",
                                     want.pol_x, want.pol_y, want.pol_z,
                                     m_data.pol_x, m_data.pol_y, m_data.pol_z);
                    end
                end
            end
        end
        pending <= pol_queue.size();
    end
endmodule

/* bench/photon_polarization_vector_test.sv */
`timescale 1ns / 100ps

module photon_polarization_vector_test;

    localparam int LATENCY     = 2 * ppv_pkg::VEC_W + 10;
    localparam int CYCLE_LIMIT = 200000;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    ppv_pkg::ppv_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    ppv_pkg::ppv_out_t m_data;
    int                fail_count;
    int                pending;
    int                cycles;

    photon_polarization_vector DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    photon_polarization_vector_check checker_inst (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog on the whole run
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver stalls on its own pattern: quiet spells and busy spells
    initial begin
        int mode;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            mode = (cycles / 97) % 3;
            if (mode == 0)
                m_ready <= 1'b1;
            else if (mode == 1)
                m_ready <= ($urandom_range(0, 3) != 0);
            else
                m_ready <= ($urandom_range(0, 2) == 0);
        end
    end

    // random component, biased toward the edges of the range
    function automatic logic signed [ppv_pkg::VEC_W-1:0] pick_comp();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sd16384;
            3:       return -16'sd16384;
            4:       return 16'sd0;
            5:       return ppv_pkg::VEC_W'($urandom);
            default: return ppv_pkg::VEC_W'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // mostly a unit-ish direction from a random pair plus a derived third, else three random components
    function automatic ppv_pkg::ppv_in_t pick_item();
        ppv_pkg::ppv_in_t it;
        int a, b, rest;
        if ($urandom_range(0, 3) != 0) begin
            a = $signed($urandom_range(0, 32768)) - 16384;
            b = $signed($urandom_range(0, 32768)) - 16384;
            if (a * a + b * b > 16384 * 16384)
                b = 0;
            rest = 16384 * 16384 - a * a - b * b;
            it.dir_x = ppv_pkg::VEC_W'(a);
            it.dir_y = ppv_pkg::VEC_W'(b);
            it.dir_z = ppv_pkg::VEC_W'($rtoi($sqrt(rest)) * ($urandom_range(0, 1) ? 1 : -1));
            if ($urandom_range(0, 9) == 0) begin
                it.dir_y = '0;
                it.dir_z = '0;
            end
        end else begin
            it.dir_x = pick_comp();
            it.dir_y = pick_comp();
            it.dir_z = pick_comp();
        end
        it.angle = ppv_pkg::ANGLE_W'($urandom);
        return it;
    endfunction

    // one transfer: hold valid and payload until accepted
    task automatic send(input ppv_pkg::ppv_in_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        ppv_pkg::ppv_in_t dir_list[$];
        ppv_pkg::ppv_in_t it;
        logic [15:0]      angs [8];
        int               burst;
        angs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                 16'h3FFF, 16'h7FFF, 16'hFFFF, 16'h2000};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: axes, x-axis direction (zero cross product), extremes, zero vector, diagonals
        dir_list.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'h0});
        dir_list.push_back('{-16'sd16384, 16'sd0, 16'sd0, 16'h0});
        dir_list.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'h0});
        dir_list.push_back('{16'sd0, 16'sd0, -16'sd16384, 16'h0});
        dir_list.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'h0});
        dir_list.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h0});
        dir_list.push_back('{16'sh7FFF, 16'sh8000, 16'sh0001, 16'h0});
        dir_list.push_back('{16'sd0, 16'sd0, 16'sd0, 16'h0});
        dir_list.push_back('{16'sd9459, 16'sd9459, 16'sd9459, 16'h0});
        dir_list.push_back('{16'sd0, 16'sd11585, 16'sd11585, 16'h0});
        for (int i = 0; i < dir_list.size(); i++) begin
            it = dir_list[i];
            it.angle = angs[i % 8];
            send(it);
            it.angle = angs[(i + 3) % 8];
            send(it);
        end
        s_valid <= 1'b0;

        // random bursts, with gaps between most of them
        for (int n = 0; n < 650; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < 650; k++, n++)
                send(pick_item());
            s_valid <= 1'b0;
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 12)) @(negedge aclk);
        end

        wait (pending == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* filelist.f */
rtl/ppv_pkg.sv
rtl/ppv_perp.sv
rtl/ppv_sincos.sv
rtl/photon_polarization_vector.sv
bench/photon_polarization_vector_check.sv
bench/photon_polarization_vector_test.sv
